@@ hdl/skcg_pkg.sv @@
package skcg_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int CFG_WIDTH    = 20;
  localparam int DIV_STEPS    = 56;

  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [31:0] LOG2E_Q30   = 32'd1549082005;
  localparam logic [31:0] DB_OCT_Q24  = 32'd101008905;
  localparam logic [31:0] OCT_DB_Q30  = 32'd178344657;
  localparam logic [31:0] USEC_PER_S  = 32'd1000000;
  localparam logic [22:0] X_MAX       = 23'd4194304;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_KNEE      = 3'd1,
    REG_RATIO     = 3'd2,
    REG_ATTACK    = 3'd3,
    REG_RELEASE   = 3'd4,
    REG_RATE      = 3'd5
  } reg_idx_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] one;
    v   = x;
    res = 64'd0;
    one = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (v >= res + one) begin
        v   = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // Entry i holds 2^(-2^-(i+1)) in Q31.
  function automatic logic [15:0][31:0] build_roots();
    logic [63:0]       prev;
    logic [15:0][31:0] t;
    prev = 64'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      prev = isqrt64(prev << 31);
      t[i] = prev[31:0];
    end
    return t;
  endfunction

  localparam logic [15:0][31:0] ROOTS = build_roots();

endpackage

@@ hdl/soft_knee_compressor_gain.sv @@
// Stereo soft-knee compressor gain stage.
// Input channel (in_valid/in_ready): one request carries a left/right sample pair in
// Q4.20 and a timestamp in samples. Output channel (out_valid/out_ready): the two
// gain-scaled samples and the applied gain in 1/16 dB.
// Configuration: write cfg_data to register cfg_index while cfg_wr_en is high;
// values saturate to their legal range, unknown indexes are dropped.
// Each request is processed by one shared 32x32 multiplier and a radix-2 divider
// (56 steps after a load state) under a sequencer. A request whose signal passes
// unchanged ends after the envelope update; otherwise the full gain curve is
// evaluated. Most of the work lies in the log normalize loop, the divider and the
// two 16-step 2^-y loops. in_ready is high only while the sequencer is idle, so
// the next request is taken at the earliest in the cycle after the
// result is loaded. Results sit in an output register, so the next request is
// taken while a result waits; if the receiver still stalls when the next result is
// done, the sequencer holds it until the output register frees.
// Reset (rst, synchronous) restores the register defaults, clears the envelope
// and forgets the last timestamp, so the first request uses one sample elapsed.
module soft_knee_compressor_gain import skcg_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_index,
  input  logic [CFG_WIDTH-1:0]           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  input  logic [47:0]                    timestamp_samples,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  output logic signed [12:0]             reduction_db16
);

  localparam int SW = SAMPLE_WIDTH;

  typedef enum logic [28:0] {
    ST_IDLE     = 29'd1 << 0,
    ST_ELAPSED  = 29'd1 << 1,
    ST_DEN_TAKE = 29'd1 << 2,
    ST_NUM_TAKE = 29'd1 << 3,
    ST_X_DIV    = 29'd1 << 4,
    ST_Y_MUL    = 29'd1 << 5,
    ST_Y_TAKE   = 29'd1 << 6,
    ST_POW_MUL  = 29'd1 << 7,
    ST_POW_TAKE = 29'd1 << 8,
    ST_POW_DONE = 29'd1 << 9,
    ST_ENV_MUL  = 29'd1 << 10,
    ST_ENV_TAKE = 29'd1 << 11,
    ST_LOG_NORM = 29'd1 << 12,
    ST_LOG_MUL  = 29'd1 << 13,
    ST_LOG_TAKE = 29'd1 << 14,
    ST_LDB_MUL  = 29'd1 << 15,
    ST_LDB_TAKE = 29'd1 << 16,
    ST_CURVE    = 29'd1 << 17,
    ST_KR_TAKE  = 29'd1 << 18,
    ST_DR_TAKE  = 29'd1 << 19,
    ST_DD_TAKE  = 29'd1 << 20,
    ST_LT_TAKE  = 29'd1 << 21,
    ST_C_DIV    = 29'd1 << 22,
    ST_G_MUL    = 29'd1 << 23,
    ST_G_TAKE   = 29'd1 << 24,
    ST_SL_MUL   = 29'd1 << 25,
    ST_SL_TAKE  = 29'd1 << 26,
    ST_SR_TAKE  = 29'd1 << 27,
    ST_DONE     = 29'd1 << 28
  } state_t;

  state_t state;

  // configuration registers
  logic signed [11:0] threshold_db16;
  logic [9:0]         knee_db16;
  logic [8:0]         ratio_q4;
  logic [19:0]        attack_us;
  logic [19:0]        release_us;
  logic [17:0]        sample_rate_hz;

  // persistent state
  logic [31:0] env;
  logic [47:0] last_ts;
  logic        have_last;

  // per-request working registers
  logic signed [SW-1:0] smp_l, smp_r;
  logic [47:0]          ts_r;
  logic [31:0]          mag;
  logic                 up;
  logic [15:0]          d_r;
  logic [37:0]          den;
  logic [22:0]          x_r;
  logic [23:0]          y;
  logic [31:0]          pw_r;
  logic [3:0]           step_j;
  logic                 for_gain;
  logic [31:0]          s_r;
  logic [31:0]          m;
  logic [4:0]           lp;
  logic [15:0]          frac;
  logic                 l_neg;
  logic signed [24:0]   ldb;
  logic [21:0]          knee_dist;
  logic [30:0]          cdiv;
  logic [23:0]          dmag;
  logic [31:0]          gain;
  logic [SW-1:0]        lo, ro;
  logic signed [12:0]   red;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] p;

  // shared divider
  logic [55:0] dq;
  logic [40:0] rem;
  logic [39:0] dv;
  logic [5:0]  div_cnt;
  logic [40:0] rem_sh;
  logic        div_ge;
  logic [40:0] rem_nx;

  // output register
  logic signed [SW-1:0] out_l, out_r;
  logic signed [12:0]   out_red;

  // combinational helpers
  logic [SW-1:0]      abs_li, abs_ri, abs_max;
  logic [SW-1:0]      abs_l, abs_r;
  logic [47:0]        ts_diff, d_full;
  logic [15:0]        cap, d_cap, d_sel;
  logic [19:0]        tc;
  logic [31:0]        env_gap;
  logic [31:0]        env_upd;
  logic [31:0]        pow_val;
  logic [6:0]         lp_off;
  logic [22:0]        lq;
  logic [22:0]        lq_abs;
  logic [23:0]        ldb_mag;
  logic signed [26:0] t_val, kh, l27, lo_edge, hi_edge, dist_c, lt_c;
  logic               in_knee, above;
  logic [8:0]         ratio_m1;
  logic [SW+31:0]     round_sum;
  logic [SW-1:0]      rounded;
  logic [24:0]        red_sum;
  logic [12:0]        red_mag;
  logic signed [11:0] cfg_thr;
  logic [9:0]         cfg_knee;
  logic [8:0]         cfg_ratio;
  logic [19:0]        cfg_time;
  logic [17:0]        cfg_rate;

  assign in_ready       = (state == ST_IDLE);
  assign left_out       = out_l;
  assign right_out      = out_r;
  assign reduction_db16 = out_red;

  always_comb begin
    abs_li  = left_in[SW-1]  ? SW'(-left_in)  : SW'(left_in);
    abs_ri  = right_in[SW-1] ? SW'(-right_in) : SW'(right_in);
    abs_max = (abs_li > abs_ri) ? abs_li : abs_ri;
    abs_l   = smp_l[SW-1] ? SW'(-smp_l) : SW'(smp_l);
    abs_r   = smp_r[SW-1] ? SW'(-smp_r) : SW'(smp_r);

    ts_diff = ts_r - last_ts;
    d_full  = (have_last && ts_r >= last_ts) ? ts_diff : 48'd1;
    cap     = sample_rate_hz[17:2];
    d_cap   = (d_full > {32'd0, cap}) ? cap : d_full[15:0];
    d_sel   = (d_cap == 16'd0) ? 16'd1 : d_cap;
    tc      = (mag > env) ? attack_us : release_us;

    env_gap = up ? (mag - env) : (env - mag);
    env_upd = up ? (env + p[62:31]) : (env - p[62:31]);
    pow_val = (y[23:21] != 3'd0) ? 32'd0 : (pw_r >> y[20:16]);

    lp_off  = {2'b00, lp} - 7'd28;
    lq      = {lp_off, frac};
    lq_abs  = l_neg ? (~lq + 23'd1) : lq;
    ldb_mag = p[47:24];

    t_val   = {{3{threshold_db16[11]}}, threshold_db16, 12'd0};
    kh      = {6'd0, knee_db16, 11'd0};
    l27     = {{2{ldb[24]}}, ldb};
    lo_edge = t_val - kh;
    hi_edge = t_val + kh;
    in_knee = (knee_db16 != 10'd0) && (l27 > lo_edge) && (l27 < hi_edge);
    above   = (l27 >= hi_edge);
    dist_c  = l27 - lo_edge;
    lt_c    = l27 - t_val;
    ratio_m1 = ratio_q4 - 9'd16;

    round_sum = (SW+32)'(p[SW+30:0]) + ((SW+32)'(1) << 30);
    rounded   = round_sum[SW+30:31];

    red_sum = {1'b0, dmag} + 25'd2048;
    red_mag = (red_sum[24:12] > 13'd3840) ? 13'd3840 : red_sum[24:12];

    rem_sh = {rem[39:0], dq[55]};
    div_ge = (rem_sh >= {1'b0, dv});
    rem_nx = div_ge ? (rem_sh - {1'b0, dv}) : rem_sh;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      ST_ELAPSED: begin
        mul_a = {12'd0, tc};
        mul_b = {14'd0, sample_rate_hz};
      end
      ST_DEN_TAKE: begin
        mul_a = {16'd0, d_r};
        mul_b = USEC_PER_S;
      end
      ST_Y_MUL: begin
        mul_a = {9'd0, x_r};
        mul_b = LOG2E_Q30;
      end
      ST_POW_MUL: begin
        mul_a = pw_r;
        mul_b = y[~step_j] ? ROOTS[step_j] : ONE_Q31;
      end
      ST_ENV_MUL: begin
        mul_a = env_gap;
        mul_b = s_r;
      end
      ST_LOG_MUL: begin
        mul_a = m;
        mul_b = m;
      end
      ST_LDB_MUL: begin
        mul_a = {11'd0, lq_abs[20:0]};
        mul_b = DB_OCT_Q24;
      end
      ST_CURVE: begin
        if (in_knee) begin
          mul_a = {22'd0, knee_db16};
          mul_b = {23'd0, ratio_q4};
        end else begin
          mul_a = {8'd0, lt_c[23:0]};
          mul_b = {23'd0, ratio_m1};
        end
      end
      ST_KR_TAKE: begin
        mul_a = {10'd0, knee_dist};
        mul_b = {23'd0, ratio_m1};
      end
      ST_DR_TAKE: begin
        mul_a = {1'b0, p[30:0]};
        mul_b = {10'd0, knee_dist};
      end
      ST_G_MUL: begin
        mul_a = {8'd0, dmag};
        mul_b = OCT_DB_Q30;
      end
      ST_SL_MUL: begin
        mul_a = 32'(abs_l);
        mul_b = gain;
      end
      ST_SL_TAKE: begin
        mul_a = 32'(abs_r);
        mul_b = gain;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // saturating register writes
  always_comb begin
    cfg_thr   = cfg_data[11:0];
    if (cfg_thr < -12'sd1600) begin
      cfg_thr = -12'sd1600;
    end else if (cfg_thr > 12'sd0) begin
      cfg_thr = 12'sd0;
    end
    cfg_knee  = (cfg_data[9:0] > 10'd640) ? 10'd640 : cfg_data[9:0];
    cfg_ratio = (cfg_data[8:0] < 9'd16) ? 9'd16 :
                (cfg_data[8:0] > 9'd320) ? 9'd320 : cfg_data[8:0];
    cfg_time  = (cfg_data[19:0] > 20'd1000000) ? 20'd1000000 : cfg_data[19:0];
    cfg_rate  = (cfg_data[17:0] == 18'd0) ? 18'd1 :
                (cfg_data[17:0] > 18'd192000) ? 18'd192000 : cfg_data[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db16 <= -12'sd384;
      knee_db16      <= 10'd480;
      ratio_q4       <= 9'd192;
      attack_us      <= 20'd3000;
      release_us     <= 20'd250000;
      sample_rate_hz <= 18'd48000;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: threshold_db16 <= cfg_thr;
        REG_KNEE:      knee_db16      <= cfg_knee;
        REG_RATIO:     ratio_q4       <= cfg_ratio;
        REG_ATTACK:    attack_us      <= cfg_time;
        REG_RELEASE:   release_us     <= cfg_time;
        REG_RATE:      sample_rate_hz <= cfg_rate;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      env       <= 32'd0;
      last_ts   <= 48'd0;
      have_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            smp_l <= left_in;
            smp_r <= right_in;
            ts_r  <= timestamp_samples;
            mag   <= 32'(abs_max) << (32 - SW);
            state <= ST_ELAPSED;
          end
        end
        ST_ELAPSED: begin
          d_r      <= d_sel;
          up       <= (mag > env);
          for_gain <= 1'b0;
          state    <= ST_DEN_TAKE;
        end
        ST_DEN_TAKE: begin
          den   <= (p[37:0] < 38'd1000000) ? 38'd1000000 : p[37:0];
          state <= ST_NUM_TAKE;
        end
        ST_NUM_TAKE: begin
          dq      <= {p[39:0], 16'd0};
          dv      <= {2'd0, den};
          rem     <= 41'd0;
          div_cnt <= 6'd0;
          state   <= ST_X_DIV;
        end
        ST_X_DIV: begin
          if (div_cnt == 6'(DIV_STEPS)) begin
            x_r   <= (dq > {33'd0, X_MAX}) ? X_MAX : dq[22:0];
            state <= ST_Y_MUL;
          end else begin
            rem     <= rem_nx;
            dq      <= {dq[54:0], div_ge};
            div_cnt <= div_cnt + 6'd1;
          end
        end
        ST_Y_MUL: state <= ST_Y_TAKE;
        ST_Y_TAKE: begin
          y      <= p[53:30];
          pw_r   <= ONE_Q31;
          step_j <= 4'd0;
          state  <= ST_POW_MUL;
        end
        ST_POW_MUL: state <= ST_POW_TAKE;
        ST_POW_TAKE: begin
          pw_r <= p[62:31];
          if (step_j == 4'd15) begin
            state <= ST_POW_DONE;
          end else begin
            step_j <= step_j + 4'd1;
            state  <= ST_POW_MUL;
          end
        end
        ST_POW_DONE: begin
          if (for_gain) begin
            gain  <= pow_val;
            state <= ST_SL_MUL;
          end else begin
            s_r   <= ONE_Q31 - pow_val;
            state <= ST_ENV_MUL;
          end
        end
        ST_ENV_MUL: state <= ST_ENV_TAKE;
        ST_ENV_TAKE: begin
          env       <= env_upd;
          last_ts   <= ts_r;
          have_last <= 1'b1;
          if (env_upd == 32'd0 || ratio_q4 == 9'd16) begin
            lo    <= smp_l;
            ro    <= smp_r;
            red   <= 13'sd0;
            state <= ST_DONE;
          end else begin
            m     <= env_upd;
            lp    <= 5'd31;
            state <= ST_LOG_NORM;
          end
        end
        ST_LOG_NORM: begin
          if (m[31]) begin
            step_j <= 4'd0;
            frac   <= 16'd0;
            l_neg  <= (lp < 5'd28);
            state  <= ST_LOG_MUL;
          end else begin
            m  <= m << 1;
            lp <= lp - 5'd1;
          end
        end
        ST_LOG_MUL: state <= ST_LOG_TAKE;
        ST_LOG_TAKE: begin
          if (p[63]) begin
            m    <= p[63:32];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= p[62:31];
            frac <= {frac[14:0], 1'b0};
          end
          if (step_j == 4'd15) begin
            state <= ST_LDB_MUL;
          end else begin
            step_j <= step_j + 4'd1;
            state  <= ST_LOG_MUL;
          end
        end
        ST_LDB_MUL: state <= ST_LDB_TAKE;
        ST_LDB_TAKE: begin
          ldb   <= l_neg ? -$signed({1'b0, ldb_mag}) : $signed({1'b0, ldb_mag});
          state <= ST_CURVE;
        end
        ST_CURVE: begin
          knee_dist <= dist_c[21:0];
          if (in_knee) begin
            state <= ST_KR_TAKE;
          end else if (above) begin
            state <= ST_LT_TAKE;
          end else begin
            dmag  <= 24'd0;
            state <= ST_G_MUL;
          end
        end
        ST_KR_TAKE: begin
          cdiv  <= {p[17:0], 13'd0};
          state <= ST_DR_TAKE;
        end
        ST_DR_TAKE: state <= ST_DD_TAKE;
        ST_DD_TAKE: begin
          dq      <= {3'd0, p[52:0]};
          dv      <= {9'd0, cdiv};
          rem     <= 41'd0;
          div_cnt <= 6'd0;
          state   <= ST_C_DIV;
        end
        ST_LT_TAKE: begin
          dq      <= {23'd0, p[32:0]};
          dv      <= {31'd0, ratio_q4};
          rem     <= 41'd0;
          div_cnt <= 6'd0;
          state   <= ST_C_DIV;
        end
        ST_C_DIV: begin
          if (div_cnt == 6'(DIV_STEPS)) begin
            dmag  <= dq[23:0];
            state <= ST_G_MUL;
          end else begin
            rem     <= rem_nx;
            dq      <= {dq[54:0], div_ge};
            div_cnt <= div_cnt + 6'd1;
          end
        end
        ST_G_MUL: state <= ST_G_TAKE;
        ST_G_TAKE: begin
          y        <= p[53:30];
          red      <= -$signed(red_mag);
          for_gain <= 1'b1;
          pw_r     <= ONE_Q31;
          step_j   <= 4'd0;
          state    <= ST_POW_MUL;
        end
        ST_SL_MUL: state <= ST_SL_TAKE;
        ST_SL_TAKE: begin
          lo    <= smp_l[SW-1] ? SW'(-rounded) : rounded;
          state <= ST_SR_TAKE;
        end
        ST_SR_TAKE: begin
          ro    <= smp_r[SW-1] ? SW'(-rounded) : rounded;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold the result until the output register frees
          if (!out_valid || out_ready) begin
            out_l   <= lo;
            out_r   <= ro;
            out_red <= red;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
